### sv/swfm_pkg.sv
`timescale 1ns / 1ps

package swfm_pkg;

	// field and register widths
	localparam int FREQ_W     = 38;
	localparam int PERIOD_W   = 32;
	localparam int STATUS_W   = 2;
	localparam int TIMEOUT_W  = 32;
	localparam int DB_CFG_W   = 16;
	localparam int RATE_W     = 30;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	// default parameter values
	localparam int COUNT_WIDTH_DEF    = 32;
	localparam int DEBOUNCE_WIDTH_DEF = 16;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// divider step counter width, one quotient bit per step
	localparam int DIV_CNT_W = $clog2(FREQ_W + 1);

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_READ_ERR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HALF_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 2'd3;

	// register reset values
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 32'd50000000;
	localparam logic [DB_CFG_W-1:0]  DEBOUNCE_RST  = 16'd1000;
	localparam logic [RATE_W-1:0]    TICK_RATE_RST = 30'd50000000;

	typedef struct packed {
		logic                 half_mode;
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [DB_CFG_W-1:0]  debounce_ticks;
		logic [RATE_W-1:0]    tick_rate_hz;
	} cfg_t;

	// one finished measurement waiting for the back end
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PERIOD_W-1:0] period;
	} job_t;

endpackage

### sv/swfm_front.sv
`timescale 1ns / 1ps

module swfm_front #(
	parameter int COUNT_WIDTH    = swfm_pkg::COUNT_WIDTH_DEF,
	parameter int DEBOUNCE_WIDTH = swfm_pkg::DEBOUNCE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  swfm_pkg::cfg_t     cfg,
	input  logic               item_fire,
	input  logic               action,
	input  logic               pin_level,
	input  logic               read_error,
	output logic               push,
	output swfm_pkg::job_t     push_job
);

	localparam int CW = COUNT_WIDTH;
	localparam int DW = DEBOUNCE_WIDTH;
	localparam int PW = (CW + 1 > 33) ? CW + 1 : 33;

	logic          busy_q, busy_d;
	logic          ref_q, ref_d;
	logic [CW-1:0] elapsed_q, elapsed_d;
	logic [CW-1:0] first_half_q, first_half_d;
	logic          half_seen_q, half_seen_d;
	logic          confirming_q, confirming_d;
	logic [DW-1:0] db_left_q, db_left_d;
	logic [CW-1:0] detect_q, detect_d;

	logic [CW-1:0]         el_inc;
	logic [DW-1:0]         db_dec;
	logic [DW+15:0]        db_wide;
	logic [DW-1:0]         db_cfg;
	logic                  do_confirm;
	logic [CW-1:0]         half;
	logic                  finished;
	logic                  period_push;
	logic [PW-1:0]         period_wide;
	logic [swfm_pkg::PERIOD_W-1:0] period_sat;

	// debounce setting fitted to the counter width
	assign db_wide = {{DW{1'b0}}, cfg.debounce_ticks};
	assign db_cfg  = db_wide[DW-1:0];

	// saturating tick count
	assign el_inc = (elapsed_q != {CW{1'b1}}) ? elapsed_q + 1'b1 : elapsed_q;
	assign db_dec = (db_left_q != '0) ? db_left_q - 1'b1 : db_left_q;

	// period saturates at the field maximum
	assign period_sat = (period_wide > PW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
		: period_wide[swfm_pkg::PERIOD_W-1:0];

	// measurement control for one transfer
	always_comb begin
		busy_d       = busy_q;
		ref_d        = ref_q;
		elapsed_d    = elapsed_q;
		first_half_d = first_half_q;
		half_seen_d  = half_seen_q;
		confirming_d = confirming_q;
		db_left_d    = db_left_q;
		detect_d     = detect_q;
		do_confirm   = 1'b0;
		half         = detect_q;
		finished     = 1'b0;
		period_push  = 1'b0;
		period_wide  = '0;
		push         = 1'b0;
		push_job     = '{status: swfm_pkg::ST_OK, period: '0};

		if (item_fire) begin
			if (action) begin
				if (read_error) begin
					busy_d = 1'b0;
					push   = 1'b1;
					push_job.status = swfm_pkg::ST_READ_ERR;
				end else begin
					busy_d       = 1'b1;
					ref_d        = pin_level;
					elapsed_d    = '0;
					first_half_d = '0;
					half_seen_d  = 1'b0;
					confirming_d = 1'b0;
					db_left_d    = '0;
					detect_d     = '0;
				end
			end else if (busy_q) begin
				elapsed_d = el_inc;
				if (read_error) begin
					busy_d = 1'b0;
					push   = 1'b1;
					push_job.status = swfm_pkg::ST_READ_ERR;
				end else begin
					// level change handling
					if (cfg.half_mode) begin
						if (pin_level != ref_q) begin
							busy_d      = 1'b0;
							finished    = 1'b1;
							period_push = 1'b1;
							period_wide = PW'({el_inc, 1'b0});
						end
					end else if (confirming_q) begin
						db_left_d = db_dec;
						if (db_dec == '0) begin
							if (pin_level != ref_q) begin
								do_confirm = 1'b1;
								half       = detect_q;
							end else begin
								confirming_d = 1'b0;
							end
						end
					end else if (pin_level != ref_q) begin
						confirming_d = 1'b1;
						detect_d     = el_inc;
						db_left_d    = db_cfg;
						if (db_cfg == '0) begin
							do_confirm = 1'b1;
							half       = el_inc;
						end
					end

					// confirmed half cycle, timed from the detection instant
					if (do_confirm) begin
						confirming_d = 1'b0;
						db_left_d    = '0;
						ref_d        = pin_level;
						elapsed_d    = el_inc - half;
						if (half_seen_q) begin
							busy_d      = 1'b0;
							half_seen_d = 1'b0;
							finished    = 1'b1;
							period_push = 1'b1;
							period_wide = PW'(first_half_q) + PW'(half);
						end else begin
							first_half_d = half;
							half_seen_d  = 1'b1;
						end
					end

					// timeout check
					if (!finished && (PW'(elapsed_d) > PW'(cfg.timeout_ticks)
						|| elapsed_d == {CW{1'b1}})) begin
						busy_d       = 1'b0;
						confirming_d = 1'b0;
						push         = 1'b1;
						push_job.status = swfm_pkg::ST_TIMEOUT;
					end

					if (period_push) begin
						push            = 1'b1;
						push_job.status = swfm_pkg::ST_OK;
						push_job.period = period_sat;
					end
				end
			end
		end
	end

	// measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			ref_q        <= 1'b0;
			elapsed_q    <= '0;
			first_half_q <= '0;
			half_seen_q  <= 1'b0;
			confirming_q <= 1'b0;
			db_left_q    <= '0;
			detect_q     <= '0;
		end else begin
			busy_q       <= busy_d;
			ref_q        <= ref_d;
			elapsed_q    <= elapsed_d;
			first_half_q <= first_half_d;
			half_seen_q  <= half_seen_d;
			confirming_q <= confirming_d;
			db_left_q    <= db_left_d;
			detect_q     <= detect_d;
		end
	end

endmodule

### sv/swfm_queue.sv
`timescale 1ns / 1ps

module swfm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  swfm_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output swfm_pkg::job_t head_job
);

	localparam int AW = swfm_pkg::QUEUE_AW;
	localparam int CNW = swfm_pkg::QUEUE_CW;

	swfm_pkg::job_t  entry_q [swfm_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CNW-1:0]  count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CNW'(swfm_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_job  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(swfm_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(swfm_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// a transfer is only offered to a queue with room
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");

endmodule

### sv/swfm_back.sv
`timescale 1ns / 1ps

module swfm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [swfm_pkg::RATE_W-1:0]       tick_rate_hz,
	input  logic                              job_valid,
	input  swfm_pkg::job_t                    job,
	output logic                              job_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [swfm_pkg::FREQ_W-1:0]       frequency_q8,
	output logic [swfm_pkg::PERIOD_W-1:0]     period_ticks,
	output logic [swfm_pkg::STATUS_W-1:0]     status
);

	localparam int FW  = swfm_pkg::FREQ_W;
	localparam int PRW = swfm_pkg::PERIOD_W;
	localparam int NW  = swfm_pkg::DIV_CNT_W;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_OUT  = 3'b100
	} back_state_t;

	back_state_t                  state_q;
	logic [FW-1:0]                num_q;
	logic [PRW-1:0]               den_q;
	logic [PRW-1:0]               rem_q;
	logic [NW-1:0]                cnt_q;
	logic [FW-1:0]                freq_q;
	logic [PRW-1:0]               period_q;
	logic [swfm_pkg::STATUS_W-1:0] status_q;

	logic [PRW:0]   rem_shift;
	logic [PRW+1:0] trial;
	logic           ge;
	logic [PRW-1:0] rem_next;
	logic [FW-1:0]  num_next;
	logic           needs_div;

	// one restoring divide step: quotient bits shift in behind the dividend
	assign rem_shift = {rem_q, num_q[FW-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, den_q};
	assign ge        = !trial[PRW+1];
	assign rem_next  = ge ? trial[PRW-1:0] : rem_shift[PRW-1:0];
	assign num_next  = {num_q[FW-2:0], ge};

	assign needs_div = (job.status == swfm_pkg::ST_OK) && (job.period != '0);
	assign job_pop   = (state_q == B_IDLE) && job_valid;

	assign out_valid    = (state_q == B_OUT);
	assign frequency_q8 = freq_q;
	assign period_ticks = period_q;
	assign status       = status_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						if (needs_div) begin
							state_q <= B_DIV;
							cnt_q   <= NW'(FW);
						end else begin
							state_q <= B_OUT;
						end
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == NW'(1)) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_ready) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// divider datapath and result register
	always_ff @(posedge clk) begin
		if (job_pop) begin
			period_q <= job.period;
			status_q <= job.status;
			num_q    <= {tick_rate_hz, 8'h00};
			den_q    <= job.period;
			rem_q    <= '0;
			freq_q   <= '0;
		end else if (state_q == B_DIV) begin
			num_q <= num_next;
			rem_q <= rem_next;
			if (cnt_q == NW'(1)) begin
				freq_q <= num_next;
			end
		end
	end

	// a failed measurement carries no figures
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != swfm_pkg::ST_OK |-> frequency_q8 == '0 && period_ticks == '0)
		else $error("failure result with nonzero figures");

	// the divide runs for a bounded number of steps
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> cnt_q != '0 && cnt_q <= NW'(FW))
		else $error("divide step count out of range");

	// a result leaves the divider only after its last step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == B_IDLE) || $past(cnt_q == NW'(1)))
		else $error("result shown before the divide finished");

endmodule

### sv/square_wave_frequency_meter.sv
`timescale 1ns / 1ps

// Square-wave frequency meter.
// Input channel (in_valid/in_ready): one transfer per pin sample. action = 1
// starts a measurement and takes pin_level as the reference level, or with
// read_error set gives a read-error result; action = 0 is a tick carrying a
// sample and a read_error flag. Ticks while idle are dropped. The front end
// takes one transfer per cycle whenever the two-entry result queue has room.
// Output channel (out_valid/out_ready): one result per finished measurement,
// with the period in ticks, the frequency with 8 fractional bits and a status
// (ok, timeout, read error). Failures carry zero figures.
// A successful result passes from the queue through the bit-serial divider
// (38 steps, one quotient bit per cycle) before out_valid rises; a failure
// result goes from the queue straight to the output register.
// When out_ready is low the result holds in the output register; the queue
// fills and in_ready then drops until the back end frees an entry.
// Configuration (cfg_write/cfg_index/cfg_data) takes one register per cycle;
// the user must write it only while the meter is idle (the block never checks).
// Reset clears the meter to idle and loads the default register values.
module square_wave_frequency_meter #(
	parameter int COUNT_WIDTH    = swfm_pkg::COUNT_WIDTH_DEF,
	parameter int DEBOUNCE_WIDTH = swfm_pkg::DEBOUNCE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [swfm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swfm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic                                pin_level,
	input  logic                                read_error,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [swfm_pkg::FREQ_W-1:0]         frequency_q8,
	output logic [swfm_pkg::PERIOD_W-1:0]       period_ticks,
	output logic [swfm_pkg::STATUS_W-1:0]       status
);

	swfm_pkg::cfg_t cfg_q;
	logic           item_fire;
	logic           push;
	swfm_pkg::job_t push_job;
	logic           q_full;
	logic           q_not_empty;
	logic           q_pop;
	swfm_pkg::job_t head_job;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_mode      <= 1'b0;
			cfg_q.timeout_ticks  <= swfm_pkg::TIMEOUT_RST;
			cfg_q.debounce_ticks <= swfm_pkg::DEBOUNCE_RST;
			cfg_q.tick_rate_hz   <= swfm_pkg::TICK_RATE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				swfm_pkg::REG_HALF_MODE: cfg_q.half_mode <= cfg_data[0];
				swfm_pkg::REG_TIMEOUT: begin
					cfg_q.timeout_ticks <= cfg_data[swfm_pkg::TIMEOUT_W-1:0];
				end
				swfm_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ticks <= cfg_data[swfm_pkg::DB_CFG_W-1:0];
				end
				swfm_pkg::REG_TICK_RATE: begin
					cfg_q.tick_rate_hz <= cfg_data[swfm_pkg::RATE_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// input transfer
	assign in_ready  = !q_full;
	assign item_fire = in_valid && in_ready;

	swfm_front #(
		.COUNT_WIDTH    (COUNT_WIDTH),
		.DEBOUNCE_WIDTH (DEBOUNCE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_fire  (item_fire),
		.action     (action),
		.pin_level  (pin_level),
		.read_error (read_error),
		.push       (push),
		.push_job   (push_job)
	);

	swfm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_job  (head_job)
	);

	swfm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_rate_hz (cfg_q.tick_rate_hz),
		.job_valid    (q_not_empty),
		.job          (head_job),
		.job_pop      (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frequency_q8 (frequency_q8),
		.period_ticks (period_ticks),
		.status       (status)
	);

endmodule
